[design/src_pkg.sv]
// Shared types and constants of the shaded ray compositor.
package src_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int DIV_STEPS  = 30;    // quotient bits below the top one
    localparam int ROOT_BITS  = 16;    // bits of the integer square root
    localparam int POW_STEPS  = 4;     // squarings for the 16th power
    localparam int UNIT_MAX   = 32767; // largest Q1.15 component

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } src_dir_t;

    typedef enum logic [2:0] {
        REG_LIGHT_X = 3'd0,
        REG_LIGHT_Y = 3'd1,
        REG_LIGHT_Z = 3'd2,
        REG_VIEW_X  = 3'd3,
        REG_VIEW_Y  = 3'd4,
        REG_VIEW_Z  = 3'd5
    } src_reg_idx_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_PREP,
        F_DIV,
        F_SQRT,
        F_DOTL,
        F_SUML,
        F_SUMV,
        F_POW,
        F_MULA,
        F_MULB
    } src_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ACC
    } src_back_state_t;

endpackage

[design/src_fifo.sv]
// Small register queue between the shading front end and the compositing back end.
module src_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = src_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule

[design/src_front.sv]
// Front end: normalizes the gradient and forms the unscaled shading factor.
module src_front #(
    parameter int FRAC_BITS = src_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  src_pkg::src_dir_t     light_dir,
    input  src_pkg::src_dir_t     view_dir,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [8:0]     s_grad_x,
    input  logic signed [8:0]     s_grad_y,
    input  logic signed [8:0]     s_grad_z,
    input  logic [15:0]           s_sample_red,
    input  logic [15:0]           s_sample_green,
    input  logic [15:0]           s_sample_blue,
    input  logic [15:0]           s_sample_alpha,
    input  logic                  s_ray_start,
    input  logic                  s_ray_end,
    output logic                  push_valid,
    input  logic                  push_full,
    output logic [FRAC_BITS:0]    push_shade,
    output logic [15:0]           push_red,
    output logic [15:0]           push_green,
    output logic [15:0]           push_blue,
    output logic [15:0]           push_alpha,
    output logic                  push_start,
    output logic                  push_end
);
    import src_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int ONE_I = 1 << F;
    localparam int C02_I = (2 * ONE_I + 5) / 10;
    localparam int C07_I = (7 * ONE_I + 5) / 10;
    localparam int C01_I = (ONE_I + 5) / 10;
    localparam logic [F:0]   ONE_V = (F + 1)'(ONE_I);
    localparam logic [F-1:0] C02_V = F'(C02_I);
    localparam logic [F-1:0] C07_V = F'(C07_I);
    localparam logic [F-1:0] C01_V = F'(C01_I);

    src_front_state_t state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic        cnt_clr, cnt_inc;

    logic [16:0]        a2_reg   [3];
    logic [2:0]         neg_reg;
    logic [17:0]        len2_reg;
    logic               len_zero_reg;
    logic [17:0]        rem_reg  [3];
    logic [30:0]        quo_reg  [3];
    logic [15:0]        root_reg [3];
    logic signed [31:0] prod_reg [3];
    logic [F:0]         nl_reg, p_reg, t1_reg;
    logic [15:0]        red_reg, green_reg, blue_reg, alpha_reg;
    logic               start_reg, end_reg;

    logic signed [8:0]  g_in [3];
    logic [8:0]         a_in [3];
    logic [16:0]        a2_in [3];
    logic signed [15:0] n_vec [3];
    logic signed [15:0] l_vec [3];
    logic signed [15:0] v_vec [3];
    logic [F:0]         dot_c;
    logic [2*F+1:0]     psq;
    logic [2*F:0]       mul_a, mul_b;
    logic [F+2:0]       shade_sum;

    assign g_in[0] = s_grad_x;
    assign g_in[1] = s_grad_y;
    assign g_in[2] = s_grad_z;
    assign l_vec[0] = light_dir.x;
    assign l_vec[1] = light_dir.y;
    assign l_vec[2] = light_dir.z;
    assign v_vec[0] = view_dir.x;
    assign v_vec[1] = view_dir.y;
    assign v_vec[2] = view_dir.z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_in[i]  = g_in[i][8] ? 9'(-g_in[i]) : 9'(g_in[i]);
            a2_in[i] = 17'(a_in[i]) * 17'(a_in[i]);
        end
    end

    // Unit normal from the root, capped and signed; zero gradient gives zero.
    always_comb begin
        logic [14:0] mag;
        for (int i = 0; i < 3; i++) begin
            mag = (root_reg[i] > 16'(UNIT_MAX)) ? 15'(UNIT_MAX) : root_reg[i][14:0];
            if (len_zero_reg) begin
                n_vec[i] = '0;
            end else if (neg_reg[i]) begin
                n_vec[i] = -$signed({1'b0, mag});
            end else begin
                n_vec[i] = $signed({1'b0, mag});
            end
        end
    end

    // |sum of products| in Q2.30, rescaled to F fraction bits, capped at one.
    always_comb begin
        logic signed [33:0] sum;
        logic [33:0]        mag;
        logic [33:0]        sh;
        sum   = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
        mag   = sum[33] ? 34'(-sum) : 34'(sum);
        sh    = mag >> (30 - F);
        dot_c = (sh > 34'(ONE_I)) ? ONE_V : sh[F:0];
    end

    assign psq       = p_reg * p_reg;
    assign mul_a     = C07_V * nl_reg;
    assign mul_b     = C01_V * p_reg;
    assign shade_sum = (F + 3)'(C02_V) + (F + 3)'(t1_reg) + (F + 3)'(mul_b[2*F:F]);

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_MULB);
    assign push_shade = (shade_sum > (F + 3)'(ONE_I)) ? ONE_V : shade_sum[F:0];
    assign push_red   = red_reg;
    assign push_green = green_reg;
    assign push_blue  = blue_reg;
    assign push_alpha = alpha_reg;
    assign push_start = start_reg;
    assign push_end   = end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cnt_clr) begin
                cnt_reg <= '0;
            end else if (cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_clr    = 1'b0;
        cnt_inc    = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = F_PREP;
                end
            end
            F_PREP: begin
                state_next = F_DIV;
                cnt_clr    = 1'b1;
            end
            F_DIV: begin
                cnt_inc = 1'b1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = F_SQRT;
                    cnt_clr    = 1'b1;
                end
            end
            F_SQRT: begin
                cnt_inc = 1'b1;
                if (cnt_reg == 5'(ROOT_BITS - 1)) begin
                    state_next = F_DOTL;
                    cnt_clr    = 1'b1;
                end
            end
            F_DOTL: state_next = F_SUML;
            F_SUML: state_next = F_SUMV;
            F_SUMV: begin
                state_next = F_POW;
                cnt_clr    = 1'b1;
            end
            F_POW: begin
                cnt_inc = 1'b1;
                if (cnt_reg == 5'(POW_STEPS - 1)) begin
                    state_next = F_MULA;
                    cnt_clr    = 1'b1;
                end
            end
            F_MULA: state_next = F_MULB;
            F_MULB: begin
                if (!push_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Datapath: one restoring divider and one root unit per lane.
    always_ff @(posedge aclk) begin
        logic [18:0] r2;
        logic [15:0] cand;
        logic [31:0] csq;
        logic        ge;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    for (int i = 0; i < 3; i++) begin
                        a2_reg[i]  <= a2_in[i];
                        neg_reg[i] <= g_in[i][8];
                    end
                    len2_reg     <= 18'(a2_in[0]) + 18'(a2_in[1]) + 18'(a2_in[2]);
                    len_zero_reg <= (a2_in[0] == '0) && (a2_in[1] == '0) && (a2_in[2] == '0);
                    red_reg      <= s_sample_red;
                    green_reg    <= s_sample_green;
                    blue_reg     <= s_sample_blue;
                    alpha_reg    <= s_sample_alpha;
                    start_reg    <= s_ray_start;
                    end_reg      <= s_ray_end;
                end
            end
            F_PREP: begin
                for (int i = 0; i < 3; i++) begin
                    ge          = (18'(a2_reg[i]) >= len2_reg);
                    rem_reg[i]  <= ge ? 18'(a2_reg[i]) - len2_reg : 18'(a2_reg[i]);
                    quo_reg[i]  <= {30'd0, ge};
                    root_reg[i] <= '0;
                end
            end
            F_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r2          = {rem_reg[i], 1'b0};
                    ge          = (r2 >= {1'b0, len2_reg});
                    rem_reg[i]  <= ge ? 18'(r2 - {1'b0, len2_reg}) : r2[17:0];
                    quo_reg[i]  <= {quo_reg[i][29:0], ge};
                end
            end
            F_SQRT: begin
                for (int i = 0; i < 3; i++) begin
                    cand = root_reg[i] | (16'd1 << (4'(ROOT_BITS - 1) - cnt_reg[3:0]));
                    csq  = cand * cand;
                    if (csq <= {1'b0, quo_reg[i]}) begin
                        root_reg[i] <= cand;
                    end
                end
            end
            F_DOTL: begin
                for (int i = 0; i < 3; i++) begin
                    prod_reg[i] <= n_vec[i] * l_vec[i];
                end
            end
            F_SUML: begin
                nl_reg <= dot_c;
                for (int i = 0; i < 3; i++) begin
                    prod_reg[i] <= n_vec[i] * v_vec[i];
                end
            end
            F_SUMV:  p_reg  <= dot_c;
            F_POW:   p_reg  <= psq[2*F:F];
            F_MULA:  t1_reg <= mul_a[2*F:F];
            default: ;
        endcase
    end
endmodule

[design/src_back.sv]
// Back end: opacity scaling, color accumulation, early termination and pixel output.
module src_back #(
    parameter int FRAC_BITS = src_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic [FRAC_BITS:0] q_shade,
    input  logic [15:0]        q_red,
    input  logic [15:0]        q_green,
    input  logic [15:0]        q_blue,
    input  logic [15:0]        q_alpha,
    input  logic               q_start,
    input  logic               q_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pixel_red,
    output logic [7:0]         m_pixel_green,
    output logic [7:0]         m_pixel_blue,
    output logic               m_ended_early
);
    import src_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int ONE_I = 1 << F;
    localparam int THR_I = (99 * ONE_I + 50) / 100;
    localparam logic [F:0]   ONE_V = (F + 1)'(ONE_I);
    localparam logic [F:0]   THR_V = (F + 1)'(THR_I);
    localparam logic [F+1:0] ACC_MAX = '1;

    src_back_state_t state_reg, state_next;

    logic [F+1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic [F-1:0] acc_op_reg;
    logic         fin_reg;
    logic [F:0]   shade_reg, light_reg, anew_reg;
    logic [15:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic         start_reg, end_reg;
    logic         out_valid_reg, early_out_reg;
    logic [7:0]   pix_r_reg, pix_g_reg, pix_b_reg;

    function automatic logic [F-1:0] to_frac(input logic [15:0] x);
        logic [F+15:0] ext;
        ext = {x, {F{1'b0}}};
        return ext[F+15:16];
    endfunction

    function automatic logic [F+1:0] acc_add(input logic [F+1:0] acc, input logic [F-1:0] s,
                                             input logic [F:0] l);
        logic [2*F:0] pr;
        logic [F+2:0] sum;
        pr  = s * l;
        sum = (F + 3)'(acc) + (F + 3)'(pr[2*F:F]);
        return (sum > (F + 3)'(ACC_MAX)) ? ACC_MAX : sum[F+1:0];
    endfunction

    function automatic logic [7:0] to_pixel(input logic [F+1:0] acc);
        logic [F+9:0] m;
        m = {acc, 8'd0} - (F + 10)'(acc);
        return (m[F+9:F] > 10'd255) ? 8'd255 : m[F+7:F];
    endfunction

    // Compositing math of the MUL and ACC back stages.
    logic [F-1:0]   eff_op;
    logic [F:0]     inv_op, inv_a;
    logic [2*F+1:0] light_pr, op_pr;
    logic [F+1:0]   nr, ng, nb;
    logic           term, done;

    always_comb begin
        eff_op   = start_reg ? '0 : acc_op_reg;
        inv_op   = ONE_V - (F + 1)'(eff_op);
        inv_a    = ONE_V - (F + 1)'(to_frac(alpha_reg));
        light_pr = shade_reg * inv_op;
        op_pr    = inv_op * inv_a;
        nr       = acc_add(acc_r_reg, to_frac(red_reg), light_reg);
        ng       = acc_add(acc_g_reg, to_frac(green_reg), light_reg);
        nb       = acc_add(acc_b_reg, to_frac(blue_reg), light_reg);
        term     = (anew_reg > THR_V);
        done     = term || end_reg;
    end

    assign q_pop         = (state_reg == B_IDLE) && !q_empty && !out_valid_reg;
    assign m_valid       = out_valid_reg;
    assign m_pixel_red   = pix_r_reg;
    assign m_pixel_green = pix_g_reg;
    assign m_pixel_blue  = pix_b_reg;
    assign m_ended_early = early_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_pop) state_next = B_MUL;
            B_MUL:   state_next = B_ACC;
            B_ACC:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            shade_reg <= q_shade;
            red_reg   <= q_red;
            green_reg <= q_green;
            blue_reg  <= q_blue;
            alpha_reg <= q_alpha;
            end_reg   <= q_end;
        end
        if (state_reg == B_MUL) begin
            light_reg <= light_pr[2*F:F];
            anew_reg  <= ONE_V - op_pr[2*F:F];
        end
        if (state_reg == B_ACC && !fin_reg && done) begin
            pix_r_reg     <= to_pixel(nr);
            pix_g_reg     <= to_pixel(ng);
            pix_b_reg     <= to_pixel(nb);
            early_out_reg <= term && !end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_r_reg     <= '0;
            acc_g_reg     <= '0;
            acc_b_reg     <= '0;
            acc_op_reg    <= '0;
            fin_reg       <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                start_reg <= q_start;
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == B_MUL && start_reg) begin
                acc_r_reg  <= '0;
                acc_g_reg  <= '0;
                acc_b_reg  <= '0;
                acc_op_reg <= '0;
                fin_reg    <= 1'b0;
            end
            if (state_reg == B_ACC && !fin_reg) begin
                acc_r_reg <= nr;
                acc_g_reg <= ng;
                acc_b_reg <= nb;
                if (!term) begin
                    acc_op_reg <= anew_reg[F-1:0];
                end
                if (done) begin
                    fin_reg       <= 1'b1;
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end
endmodule

[design/shaded_ray_compositor.sv]
// Top level of the shaded ray compositor: register file, front end, queue and back end.
//
//  channel  | ports                  | beat
//  ---------+------------------------+---------------------------------------------
//  s_       | s_valid / s_ready      | one ray sample: gradient, color, alpha, flags
//  m_       | m_valid / m_ready      | one pixel: RGB and early-termination flag
//  config   | psel/penable/pwrite    | light and view direction, 4 bytes apart
//
// The front end normalizes the gradient with a 30-step restoring divider and a
// 16-step square root (three lanes); it takes a sample only once the last is pushed.
// The back end works on one sample at a time; a 2-entry queue sits between them.
// Reset is synchronous, active low, and clears all control and ray state.
// A pixel waiting on m_ready stalls only the back end; the front keeps working
// until the queue fills.
module shaded_ray_compositor #(
    parameter int FRAC_BITS   = src_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = src_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // sample channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic signed [8:0] s_grad_x,
    input  logic signed [8:0] s_grad_y,
    input  logic signed [8:0] s_grad_z,
    input  logic [15:0]       s_sample_red,
    input  logic [15:0]       s_sample_green,
    input  logic [15:0]       s_sample_blue,
    input  logic [15:0]       s_sample_alpha,
    input  logic              s_ray_start,
    input  logic              s_ray_end,
    // pixel channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_pixel_red,
    output logic [7:0]        m_pixel_green,
    output logic [7:0]        m_pixel_blue,
    output logic              m_ended_early
);
    import src_pkg::*;

    localparam int QW = FRAC_BITS + 1 + 4 * 16 + 2;

    // Direction registers, signed Q1.15. Light defaults to the diagonal,
    // view to +z.
    src_dir_t     light_reg, view_reg;
    src_reg_idx_t wr_idx;
    logic         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = src_reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg <= '{x: 16'sd18919, y: 16'sd18919, z: 16'sd18919};
            view_reg  <= '{x: 16'sd0, y: 16'sd0, z: 16'sd32767};
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_LIGHT_X: light_reg.x <= pwdata[15:0];
                REG_LIGHT_Y: light_reg.y <= pwdata[15:0];
                REG_LIGHT_Z: light_reg.z <= pwdata[15:0];
                REG_VIEW_X:  view_reg.x  <= pwdata[15:0];
                REG_VIEW_Y:  view_reg.y  <= pwdata[15:0];
                REG_VIEW_Z:  view_reg.z  <= pwdata[15:0];
                default:     ;  // unmapped addresses are ignored
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_LIGHT_X: prdata = {16'd0, light_reg.x};
            REG_LIGHT_Y: prdata = {16'd0, light_reg.y};
            REG_LIGHT_Z: prdata = {16'd0, light_reg.z};
            REG_VIEW_X:  prdata = {16'd0, view_reg.x};
            REG_VIEW_Y:  prdata = {16'd0, view_reg.y};
            REG_VIEW_Z:  prdata = {16'd0, view_reg.z};
            default:     prdata = '0;
        endcase
    end

    // Front end -> queue
    logic               push_valid, q_full, q_empty, q_pop;
    logic [FRAC_BITS:0] f_shade, b_shade;
    logic [15:0]        f_red, f_green, f_blue, f_alpha;
    logic [15:0]        b_red, b_green, b_blue, b_alpha;
    logic               f_start, f_end, b_start, b_end;
    logic [QW-1:0]      q_wdata, q_rdata;

    src_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .light_dir      (light_reg),
        .view_dir       (view_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_grad_x       (s_grad_x),
        .s_grad_y       (s_grad_y),
        .s_grad_z       (s_grad_z),
        .s_sample_red   (s_sample_red),
        .s_sample_green (s_sample_green),
        .s_sample_blue  (s_sample_blue),
        .s_sample_alpha (s_sample_alpha),
        .s_ray_start    (s_ray_start),
        .s_ray_end      (s_ray_end),
        .push_valid     (push_valid),
        .push_full      (q_full),
        .push_shade     (f_shade),
        .push_red       (f_red),
        .push_green     (f_green),
        .push_blue      (f_blue),
        .push_alpha     (f_alpha),
        .push_start     (f_start),
        .push_end       (f_end)
    );

    assign q_wdata = {f_shade, f_red, f_green, f_blue, f_alpha, f_start, f_end};
    assign {b_shade, b_red, b_green, b_blue, b_alpha, b_start, b_end} = q_rdata;

    src_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    src_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_shade       (b_shade),
        .q_red         (b_red),
        .q_green       (b_green),
        .q_blue        (b_blue),
        .q_alpha       (b_alpha),
        .q_start       (b_start),
        .q_end         (b_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_red   (m_pixel_red),
        .m_pixel_green (m_pixel_green),
        .m_pixel_blue  (m_pixel_blue),
        .m_ended_early (m_ended_early)
    );
endmodule

[tb/shaded_ray_compositor_tb.sv]
// Self-checking testbench for the shaded ray compositor: lit front-to-back ray compositing.
`timescale 1ns / 100ps

module shaded_ray_compositor_tb;
    import src_pkg::*;

    // Fixed-point constants of the shading recurrence (16 fraction bits)
    localparam int              FRAC      = 16;
    localparam longint unsigned ONE       = 64'd1 << FRAC;
    localparam longint unsigned ACC_SAT   = (64'd1 << (FRAC + 2)) - 1;
    localparam longint unsigned K_AMBIENT = (2 * ONE + 5) / 10;
    localparam longint unsigned K_DIFFUSE = (7 * ONE + 5) / 10;
    localparam longint unsigned K_SPEC    = (ONE + 5) / 10;
    localparam longint unsigned OPAQUE    = (99 * ONE + 50) / 100;
    // Samples can still be in flight in the front end, queue and back end
    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic signed [8:0] gx, gy, gz;
        logic [15:0]       red, green, blue, alpha;
        logic              start, last;
    } ray_sample_t;

    typedef struct packed {
        logic [7:0] red, green, blue;
        logic       early;
    } pixel_t;

    logic              aclk, aresetn;
    logic              psel, penable, pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata, prdata;
    logic              pready;
    logic              s_valid, s_ready;
    logic signed [8:0] s_grad_x, s_grad_y, s_grad_z;
    logic [15:0]       s_sample_red, s_sample_green, s_sample_blue, s_sample_alpha;
    logic              s_ray_start, s_ray_end;
    logic              m_valid, m_ready;
    logic [7:0]        m_pixel_red, m_pixel_green, m_pixel_blue;
    logic              m_ended_early;

    shaded_ray_compositor u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_grad_x(s_grad_x), .s_grad_y(s_grad_y), .s_grad_z(s_grad_z),
        .s_sample_red(s_sample_red), .s_sample_green(s_sample_green),
        .s_sample_blue(s_sample_blue), .s_sample_alpha(s_sample_alpha),
        .s_ray_start(s_ray_start), .s_ray_end(s_ray_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_red(m_pixel_red), .m_pixel_green(m_pixel_green),
        .m_pixel_blue(m_pixel_blue), .m_ended_early(m_ended_early)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Shadow of the block: direction registers and ray accumulators
    longint          light_dir[3];
    longint          view_dir[3];
    longint unsigned sum_red, sum_green, sum_blue, opacity;
    bit              ray_done;

    pixel_t pending_pixels[$];
    int     mismatches;
    bit     idle_on;
    int     stall_cycles;

    // Q1.15 normal component: floor(|g| * 2^15 / |grad|), capped at 32767
    function automatic longint unit_comp(longint g, longint unsigned len2);
        longint unsigned mag, goal, q, c;
        mag  = (g < 0) ? -g : g;
        goal = (mag * mag) << 30;
        q    = 0;
        if (len2 == 0) return 0;
        for (int b = 15; b >= 0; b--) begin
            c = q | (64'd1 << b);
            if (c * c * len2 <= goal) q = c;
        end
        if (q > UNIT_MAX) q = UNIT_MAX;
        return (g < 0) ? -longint'(q) : longint'(q);
    endfunction

    // |n . d| in Q2.30 brought to FRAC bits, saturated at one
    function automatic longint unsigned sat_dot(longint n[3], longint d[3]);
        longint          dot;
        longint unsigned m;
        dot = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
        m   = (dot < 0) ? -dot : dot;
        m   = (m * ONE) >> 30;
        return (m > ONE) ? ONE : m;
    endfunction

    function automatic longint unsigned add_color(longint unsigned acc, logic [15:0] c,
                                                  longint unsigned light);
        longint unsigned s;
        s = acc + ((longint'(c) * light) >> FRAC);
        return (s > ACC_SAT) ? ACC_SAT : s;
    endfunction

    function automatic logic [7:0] quantize(longint unsigned acc);
        longint unsigned p;
        p = (acc * 255) >> FRAC;
        return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    // Advance the shadow state by one sample; returns 1 when a pixel is due
    function automatic bit composite_sample(input ray_sample_t s, output pixel_t px);
        longint          grad[3], nrm[3];
        longint unsigned len2, nl, spec, light, a_new;
        bit              finish;
        px = '0;
        if (s.start) begin
            sum_red = 0; sum_green = 0; sum_blue = 0; opacity = 0;
            ray_done = 0;
        end
        if (ray_done) return 0;
        grad[0] = s.gx; grad[1] = s.gy; grad[2] = s.gz;
        len2 = grad[0] * grad[0] + grad[1] * grad[1] + grad[2] * grad[2];
        for (int i = 0; i < 3; i++) nrm[i] = unit_comp(grad[i], len2);
        nl   = sat_dot(nrm, light_dir);
        spec = sat_dot(nrm, view_dir);
        for (int i = 0; i < POW_STEPS; i++) spec = (spec * spec) >> FRAC;
        light = K_AMBIENT + ((K_DIFFUSE * nl) >> FRAC) + ((K_SPEC * spec) >> FRAC);
        if (light > ONE) light = ONE;
        light = (light * (ONE - opacity)) >> FRAC;
        sum_red   = add_color(sum_red, s.red, light);
        sum_green = add_color(sum_green, s.green, light);
        sum_blue  = add_color(sum_blue, s.blue, light);
        a_new = ONE - (((ONE - opacity) * (ONE - longint'(s.alpha))) >> FRAC);
        // early termination keeps the old opacity
        if (a_new > OPAQUE) begin
            finish   = 1;
            px.early = !s.last;
        end else begin
            opacity = a_new;
            finish  = s.last;
        end
        if (!finish) return 0;
        ray_done    = 1;
        px.red      = quantize(sum_red);
        px.green    = quantize(sum_green);
        px.blue     = quantize(sum_blue);
        return 1;
    endfunction

    // Send one sample beat; prediction runs once the beat is accepted
    task automatic send_sample(ray_sample_t s);
        pixel_t px;
        if (idle_on) begin
            while ($urandom_range(99) < 8) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_grad_x       <= s.gx;
        s_grad_y       <= s.gy;
        s_grad_z       <= s.gz;
        s_sample_red   <= s.red;
        s_sample_green <= s.green;
        s_sample_blue  <= s.blue;
        s_sample_alpha <= s.alpha;
        s_ray_start    <= s.start;
        s_ray_end      <= s.last;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (composite_sample(s, px)) pending_pixels.push_back(px);
    endtask

    // Wait for every pixel, then let samples that give none flush through
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(src_reg_idx_t idx, logic signed [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= {{16{value[15]}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LIGHT_X: light_dir[0] = value;
            REG_LIGHT_Y: light_dir[1] = value;
            REG_LIGHT_Z: light_dir[2] = value;
            REG_VIEW_X:  view_dir[0]  = value;
            REG_VIEW_Y:  view_dir[1]  = value;
            REG_VIEW_Z:  view_dir[2]  = value;
            default: ;
        endcase
    endtask

    task automatic set_directions(logic signed [15:0] lx, ly, lz, vx, vy, vz);
        write_reg(REG_LIGHT_X, lx);
        write_reg(REG_LIGHT_Y, ly);
        write_reg(REG_LIGHT_Z, lz);
        write_reg(REG_VIEW_X, vx);
        write_reg(REG_VIEW_Y, vy);
        write_reg(REG_VIEW_Z, vz);
    endtask

    function automatic ray_sample_t mk(int gx, gy, gz, int r, g, b, a, bit st, bit en);
        ray_sample_t s;
        s.gx = 9'(gx); s.gy = 9'(gy); s.gz = 9'(gz);
        s.red = 16'(r); s.green = 16'(g); s.blue = 16'(b); s.alpha = 16'(a);
        s.start = st; s.last = en;
        return s;
    endfunction

    // Random sample; gradients span the full 9-bit range, including -256
    function automatic ray_sample_t rand_sample(bit st, bit en);
        ray_sample_t s;
        s.gx = 9'($urandom); s.gy = 9'($urandom); s.gz = 9'($urandom);
        if ($urandom_range(19) == 0) begin
            s.gx = '0; s.gy = '0; s.gz = '0;
        end
        s.red = 16'($urandom); s.green = 16'($urandom); s.blue = 16'($urandom);
        case ($urandom_range(9))
            0:       s.alpha = 16'($urandom_range(16'hFF00, 16'hFFFF));
            1, 2:    s.alpha = 16'($urandom);
            default: s.alpha = 16'($urandom_range(0, 9000));
        endcase
        s.start = st;
        s.last  = en;
        return s;
    endfunction

    // No ray_start after reset, extremes, zero gradient, termination cases
    task automatic test_directed();
        send_sample(mk(0, 0, 0, 16'hFFFF, 0, 16'h8000, 16'h1000, 0, 0));
        send_sample(mk(255, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1));
        send_sample(mk(-255, 0, 0, 0, 0, 0, 0, 0, 0));          // finished ray: ignored
        send_sample(mk(-255, -255, -255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 0));
        send_sample(mk(0, 0, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        send_sample(mk(0, 0, -255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1));
        send_sample(mk(1, 0, 0, 16'h1234, 16'h5678, 16'h9ABC, 16'hFFFF, 1, 0)); // early end
        send_sample(mk(0, 1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1));        // ignored
        send_sample(mk(0, -1, 0, 16'h4000, 16'h4000, 16'h4000, 16'hFFFF, 1, 1)); // opaque last
        send_sample(mk(-256, -256, -256, 16'hFFFF, 0, 0, 16'h8000, 1, 0));
        send_sample(mk(0, 0, 0, 0, 16'hFFFF, 0, 16'h8000, 0, 0));
        send_sample(mk(100, -7, 3, 0, 0, 16'hFFFF, 16'hFD00, 0, 0));
        send_sample(mk(5, 5, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0100, 0, 1));
        send_sample(mk(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 0));
        send_sample(mk(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        send_sample(mk(255, -255, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1));   // saturation
        send_sample(mk(0, 255, 0, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1, 1));
        drain_pipeline();
    endtask

    // Rays of random length with random content, plus a share of stray flags
    task automatic test_random_rays(int count);
        int sent, len;
        bit st, en;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                st = (k == 0);
                en = (k == len - 1);
                if ($urandom_range(9) == 0) begin
                    st = 1'($urandom);
                    en = 1'($urandom);
                end
                send_sample(rand_sample(st, en));
                sent++;
            end
        end
        drain_pipeline();
    endtask

    task automatic test_config_sweep();
        // axis-aligned unit light and view
        set_directions(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0);
        test_random_rays(220);
        // extreme, non-unit directions saturate the dot products
        set_directions(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                       16'sd32767);
        test_random_rays(220);
        // zero light and view: only the ambient term is left
        set_directions(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        idle_on = 0;
        test_random_rays(200);
        idle_on = 1;
        set_directions(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        test_random_rays(200);
    endtask

    // Result side: random backpressure, checks and the stall watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 8);
        end
    end

    // Sample at the falling edge: these values hold through the next rising edge
    always @(negedge aclk) begin
        pixel_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles > STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel beat %0d %0d %0d early %0b",
                                 m_pixel_red, m_pixel_green, m_pixel_blue, m_ended_early);
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.red !== m_pixel_red || want.green !== m_pixel_green ||
                        want.blue !== m_pixel_blue || want.early !== m_ended_early) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: exp %0d %0d %0d early %0b, got %0d %0d %0d early %0b",
                                     want.red, want.green, want.blue, want.early,
                                     m_pixel_red, m_pixel_green, m_pixel_blue, m_ended_early);
                    end
                end
            end
        end
    end

    initial begin
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_grad_x       <= '0;
        s_grad_y       <= '0;
        s_grad_z       <= '0;
        s_sample_red   <= '0;
        s_sample_green <= '0;
        s_sample_blue  <= '0;
        s_sample_alpha <= '0;
        s_ray_start    <= 1'b0;
        s_ray_end      <= 1'b0;
        mismatches     = 0;
        stall_cycles   = 0;
        idle_on        = 1;
        light_dir      = '{18919, 18919, 18919};
        view_dir       = '{0, 0, 32767};
        sum_red = 0; sum_green = 0; sum_blue = 0; opacity = 0; ray_done = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_rays(250);      // reset directions
        test_config_sweep();

        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[shaded_ray_compositor.f]
design/src_pkg.sv
design/src_fifo.sv
design/src_front.sv
design/src_back.sv
design/shaded_ray_compositor.sv
tb/shaded_ray_compositor_tb.sv
